>>> rtl/wrr_pkg.sv
`timescale 1ns / 1ps

package wrr_pkg;

    // number of outputs served, at most eight
    localparam int NUM_OUTPUTS = 8;

    localparam int MAX_OUTPUTS = 8;
    localparam int PORT_W      = 3;
    localparam int WEIGHT_W    = 8;
    localparam int CREDIT_W    = 8;

    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 4;

    typedef logic [MAX_OUTPUTS-1:0]               mask_t;
    typedef logic [PORT_W-1:0]                    port_t;
    typedef logic [CREDIT_W-1:0]                  credit_t;
    typedef logic [MAX_OUTPUTS-1:0][WEIGHT_W-1:0] weights_t;
    typedef logic [MAX_OUTPUTS-1:0][PORT_W-1:0]   order_t;

    // register map, selected by paddr[3]
    typedef enum logic
    {
        REG_WEIGHTS = 1'b0,
        REG_ORDER   = 1'b1
    } reg_sel_t;

    localparam weights_t WEIGHTS_RESET = 64'h0101_0101_0101_0101;
    localparam order_t   ORDER_RESET   = 24'hFA_C688;

endpackage

>>> rtl/wrr_if.sv
`timescale 1ns / 1ps

interface wrr_in_if;
    import wrr_pkg::*;

    logic  valid;
    logic  ready;
    mask_t ready_mask;

    modport source (output valid, output ready_mask, input ready);
    modport sink   (input valid, input ready_mask, output ready);
endinterface

interface wrr_out_if;
    import wrr_pkg::*;

    logic  valid;
    logic  ready;
    logic  has_target;
    port_t target;

    modport source (output valid, output has_target, output target, input ready);
    modport sink   (input valid, input has_target, input target, output ready);
endinterface

>>> rtl/weighted_round_robin_selector.sv
`timescale 1ns / 1ps
// an accepted input beat passes the input register, then the result register
// throughput: one beat per cycle unless the output stalls, set by the combinational
// credit scan between the input and result registers, which writes the credits back
// reset (rst_n low, asynchronous): pipeline empty, all credits zero, every weight one,
// scan order 0 to 7

module weighted_round_robin_selector
(
    input  logic                        clk,
    input  logic                        rst_n,

    wrr_in_if.sink                      in_ch,
    wrr_out_if.source                   out_ch,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wrr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [wrr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [wrr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                        pready
);
    import wrr_pkg::*;

    // configuration registers
    weights_t weights_reg;
    order_t   order_reg;
    reg_sel_t reg_sel;
    logic     cfg_write;

    // input stage
    logic     s1_vld_reg;
    mask_t    s1_mask_reg;

    // result stage
    logic     out_vld_reg;
    logic     has_target_reg;
    logic     has_target_next;
    port_t    target_reg;
    port_t    target_next;

    // credit state, one counter per output
    credit_t  credits_reg  [NUM_OUTPUTS];
    credit_t  credits_next [NUM_OUTPUTS];

    // handshake
    logic     out_free;
    logic     s1_move;
    logic     in_take;

    // scan results
    logic     any_ready;
    logic     hit_found;
    port_t    hit_port;
    logic     refill_found;
    port_t    refill_port;

    //------------------------------------------------------------------
    // apb register port, always ready, write on the access phase
    //------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_sel   = reg_sel_t'(paddr[3]);
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb
    begin
        case (reg_sel)
            REG_WEIGHTS: prdata = weights_reg;
            REG_ORDER:   prdata = {{(CFG_DATA_W-$bits(order_t)){1'b0}}, order_reg};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weights_reg <= WEIGHTS_RESET;
            order_reg   <= ORDER_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_WEIGHTS: weights_reg <= pwdata;
                REG_ORDER:   order_reg   <= pwdata[$bits(order_t)-1:0];
                default:     ;
            endcase
        end
    end

    //------------------------------------------------------------------
    // flow control: the result register frees itself when its beat is
    // taken, so a new beat can be scanned while the old one leaves
    //------------------------------------------------------------------
    assign out_free    = !out_vld_reg || out_ch.ready;
    assign s1_move     = s1_vld_reg && out_free;
    assign in_take     = in_ch.valid && in_ch.ready;
    assign in_ch.ready = !s1_vld_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_vld_reg <= in_ch.valid;
        end
    end

    // mask register holds payload only
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_mask_reg <= in_ch.ready_mask;
        end
    end

    //------------------------------------------------------------------
    // priority scan: walk the scan positions once, tracking both the
    // first ready output with credit and the first ready output with a
    // nonzero weight (the pick after a refill)
    //------------------------------------------------------------------
    always_comb
    begin
        logic  elig;
        port_t o;

        any_ready    = 1'b0;
        hit_found    = 1'b0;
        hit_port     = '0;
        refill_found = 1'b0;
        refill_port  = '0;
        for (int pos = 0; pos < NUM_OUTPUTS; pos++)
        begin
            o    = order_reg[pos];
            // out-of-range output numbers are skipped, unused mask bits ignored
            elig = (int'(o) < NUM_OUTPUTS) && s1_mask_reg[o];
            if (elig)
            begin
                any_ready = 1'b1;
                if (!hit_found && (credits_reg[o] != '0))
                begin
                    hit_found = 1'b1;
                    hit_port  = o;
                end
                if (!refill_found && (weights_reg[o] != '0))
                begin
                    refill_found = 1'b1;
                    refill_port  = o;
                end
            end
        end
    end

    //------------------------------------------------------------------
    // credit update and result
    //------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < NUM_OUTPUTS; i++)
        begin
            credits_next[i] = credits_reg[i];
        end
        has_target_next = 1'b0;
        target_next     = '0;

        if (hit_found)
        begin
            // normal case: debit the first ready output that has credit
            credits_next[hit_port] = credits_reg[hit_port] - credit_t'(1);
            has_target_next        = 1'b1;
            target_next            = hit_port;
        end
        else if (any_ready)
        begin
            // ready outputs but no credit: reload all, then debit the pick
            for (int i = 0; i < NUM_OUTPUTS; i++)
            begin
                credits_next[i] = weights_reg[i];
            end
            if (refill_found)
            begin
                credits_next[refill_port] = weights_reg[refill_port] - credit_t'(1);
                has_target_next           = 1'b1;
                target_next               = refill_port;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_OUTPUTS; i++)
            begin
                credits_reg[i] <= '0;
            end
        end
        else if (s1_move)
        begin
            for (int i = 0; i < NUM_OUTPUTS; i++)
            begin
                credits_reg[i] <= credits_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            has_target_reg <= has_target_next;
            target_reg     <= target_next;
        end
    end

    assign out_ch.valid      = out_vld_reg;
    assign out_ch.has_target = has_target_reg;
    assign out_ch.target     = target_reg;

endmodule

>>> rtl/wrr_checker.sv
`timescale 1ns / 1ps

module wrr_assertions
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic                   has_target,
    input logic [wrr_pkg::PORT_W-1:0] target
);
    import wrr_pkg::*;

    // no result beat straight out of reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result beat present right after reset");

    // a beat without a chosen output reports target zero
    a_no_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !has_target) |-> (target == '0))
        else $error("target nonzero with no output chosen");

    // a stalled result beat stays
    a_stall_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result beat dropped while stalled");

    // chosen output stays in range while a beat is shown
    a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && has_target) |-> (int'(target) < NUM_OUTPUTS))
        else $error("chosen output out of range");

endmodule

bind weighted_round_robin_selector wrr_assertions u_wrr_assertions
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .has_target (out_ch.has_target),
    .target     (out_ch.target)
);

>>> bench/wrr_checker.sv
`timescale 1ns / 1ps

module wrr_checker
(
    input  logic                  clk,
    input  logic                  rst_n,

    wrr_in_if                     in_ch,
    wrr_out_if                    out_ch,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [wrr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [wrr_pkg::CFG_DATA_W-1:0] pwdata,

    output int                    pending,
    output int                    fail_count
);
    import wrr_pkg::*;

    typedef struct packed
    {
        logic  has_target;
        port_t target;
    } pick_t;

    weights_t weights;
    order_t   order;
    credit_t  credits [MAX_OUTPUTS];
    pick_t    picks_q [$];

    // one scan in priority order, and if outputs are ready but out of credit,
    // a reload from the weights followed by a second scan
    function automatic pick_t pick_output(input mask_t m);
        pick_t p    = '0;
        logic  seen = 1'b0;
        int    o;
        for (int pass = 0; pass < 2; pass++)
        begin
            if (pass == 1)
            begin
                if (!seen)
                    return p;
                for (int k = 0; k < NUM_OUTPUTS; k++)
                    credits[k] = weights[k];
            end
            for (int pos = 0; pos < NUM_OUTPUTS; pos++)
            begin
                o = int'(order[pos]);
                if (o >= NUM_OUTPUTS || !m[o])
                    continue;
                seen = 1'b1;
                if (credits[o] != '0)
                begin
                    credits[o]   = credits[o] - credit_t'(1);
                    p.has_target = 1'b1;
                    p.target     = port_t'(o);
                    return p;
                end
            end
        end
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pick_t want;
        if (!rst_n)
        begin
            weights    = WEIGHTS_RESET;
            order      = ORDER_RESET;
            for (int k = 0; k < MAX_OUTPUTS; k++)
                credits[k] = '0;
            picks_q.delete();
            fail_count = 0;
            pending   <= 0;
        end
        else
        begin
            // result beats first: a beat leaving now never belongs to one arriving now
            if (out_ch.valid && out_ch.ready)
            begin
                if (picks_q.size() == 0)
                begin
                    $error("result beat with nothing expected: has_target %0d target %0d",
                           out_ch.has_target, out_ch.target);
                    fail_count++;
                end
                else
                begin
                    want = picks_q.pop_front();
                    if (out_ch.has_target !== want.has_target)
                    begin
                        $error("has_target: expected %0d, actual %0d",
                               want.has_target, out_ch.has_target);
                        fail_count++;
                    end
                    if (out_ch.target !== want.target)
                    begin
                        $error("target: expected %0d, actual %0d",
                               want.target, out_ch.target);
                        fail_count++;
                    end
                end
            end

            if (in_ch.valid && in_ch.ready)
                picks_q.insert(picks_q.size(), pick_output(in_ch.ready_mask));

            if (psel && penable && pwrite && pready)
            begin
                case (reg_sel_t'(paddr[3]))
                    REG_WEIGHTS: weights = weights_t'(pwdata);
                    REG_ORDER:   order   = order_t'(pwdata[$bits(order_t)-1:0]);
                    default:     ;
                endcase
            end

            pending <= picks_q.size();
        end
    end

endmodule

>>> bench/tb_weighted_round_robin_selector.sv
`timescale 1ns / 1ps

module tb_weighted_round_robin_selector;
    import wrr_pkg::*;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 200;
    // the limit leaves a wide margin over the slowest run
    localparam int CYCLE_LIMIT     = 400000;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int pending;
    int fail_count;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int cycles        = 0;

    wrr_in_if  in_ch ();
    wrr_out_if out_ch ();

    weighted_round_robin_selector dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // watches both channels and the config port, predicts every result beat
    wrr_checker u_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver side: random back-pressure at the rate of the current phase
    always @(posedge clk)
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // setup cycle, then access cycle; the register takes the value at the
    // edge where penable and pready are both high
    task automatic cfg_write(input reg_sel_t sel, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // holds valid until the beat is taken; idle gaps drawn at the phase rate
    task automatic send_mask(input mask_t m);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.ready_mask <= m;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // stop sending and wait for every predicted result beat to come out;
    // the first edge lets the checker count a beat taken on the last edge
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic mask_t rand_mask();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return '0;
            1, 2:    return mask_t'(1) << $urandom_range(0, MAX_OUTPUTS - 1);
            3:       return '1;
            default: return mask_t'($urandom_range(0, 255));
        endcase
    endfunction

    // 0 reset value, 1 all zero, 2 all max, 3 small, 4 mixed extremes
    function automatic weights_t make_weights(input int kind);
        weights_t w;
        w = WEIGHTS_RESET;
        for (int k = 0; k < MAX_OUTPUTS; k++)
        begin
            case (kind)
                1:       w[k] = '0;
                2:       w[k] = '1;
                3:       w[k] = 8'($urandom_range(0, 3));
                4:
                begin
                    case ($urandom_range(0, 5))
                        0:       w[k] = '0;
                        1:       w[k] = '1;
                        2:       w[k] = 8'($urandom_range(0, 255));
                        default: w[k] = 8'($urandom_range(1, 4));
                    endcase
                end
                default: ;
            endcase
        end
        return w;
    endfunction

    // 0 reset order, 1 shuffled, 2 random with repeats, 3 one output everywhere,
    // 4 reversed
    function automatic order_t make_order(input int kind);
        order_t o;
        port_t  tmp;
        int     j;
        port_t  only;
        o    = ORDER_RESET;
        only = port_t'($urandom_range(0, MAX_OUTPUTS - 1));
        for (int k = 0; k < MAX_OUTPUTS; k++)
        begin
            case (kind)
                2:       o[k] = port_t'($urandom_range(0, MAX_OUTPUTS - 1));
                3:       o[k] = only;
                4:       o[k] = port_t'(MAX_OUTPUTS - 1 - k);
                default: ;
            endcase
        end
        if (kind == 1)
        begin
            for (int k = MAX_OUTPUTS - 1; k > 0; k--)
            begin
                j    = $urandom_range(0, k);
                tmp  = o[k];
                o[k] = o[j];
                o[j] = tmp;
            end
        end
        return o;
    endfunction

    initial
    begin
        order_t order_val;
        int     wkind;
        int     okind;

        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.ready_mask <= '0;
        rst_n            <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset config: nothing ready, single ends, then a full
        // round of all-ready so every credit is spent and reloaded
        send_mask(8'h00);
        send_mask(8'h01);
        send_mask(8'h80);
        repeat (9) send_mask(8'hFF);
        send_mask(8'hAA);
        send_mask(8'h55);
        drain();

        // repeated order entries and outputs that are never scanned:
        // positions 0..2 output 6, 3..4 output 0, 5..7 output 7
        order_val = {3'd7, 3'd7, 3'd7, 3'd0, 3'd0, 3'd6, 3'd6, 3'd6};
        // output 0 weight 3, output 7 weight max, the rest zero
        cfg_write(REG_WEIGHTS, 64'hFF00_0000_0000_0003);
        cfg_write(REG_ORDER, {40'b0, order_val});
        send_mask(8'h40);   // output 6 still holds credit from before: picked despite zero weight
        send_mask(8'h41);
        send_mask(8'hC1);
        send_mask(8'hBE);
        send_mask(8'h3E);   // ready outputs absent from the order count as not ready
        send_mask(8'hFF);
        send_mask(8'h00);
        drain();

        // random phases, each with its own config and idling mix
        for (int p = 0; p < PHASES; p++)
        begin
            wkind = (p < 5) ? p : $urandom_range(3, 4);
            okind = (p < 5) ? (p + 1) % 5 : $urandom_range(1, 2);
            drain();
            cfg_write(REG_WEIGHTS, make_weights(wkind));
            cfg_write(REG_ORDER, {40'b0, make_order(okind)});
            case (p % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 47; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 47; end
                default: begin send_idle_pct = 15; stall_pct = 15; end
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // mid-phase the sender holds off until the pipe is empty
                if (i == ITEMS_PER_PHASE / 2)
                    drain();
                send_mask(rand_mask());
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
